/* hdl/atrfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atrfp_pkg
// Types, codes and helper functions shared by the AT response and frame parser.
// ----------------------------------------------------------------------------
package atrfp_pkg;

    // Default response line buffer size in bytes.
    localparam int LINE_SIZE_DEF = 128;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_TIMEOUT_EN = 3'h0;

    // Length of the timeout prefix of a response line.
    localparam int PREFIX_LEN = 8;

    // Characters that the parser recognizes.
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CLR_TO  = 2'd2
    } t_kind;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_HUNT      = 3'd0,
        MODE_LINE      = 3'd1,
        MODE_FRAME     = 3'd2,
        MODE_LINE_DONE = 3'd3,
        MODE_LINE_LONG = 3'd4
    } t_mode;

    // Frame header steps.
    typedef enum logic [2:0] {
        STEP_COMMA1 = 3'd0,
        STEP_ADDR   = 3'd1,
        STEP_COMMA2 = 3'd2,
        STEP_LEN    = 3'd3,
        STEP_COMMA3 = 3'd4,
        STEP_DATA   = 3'd5
    } t_step;

    // Event codes reported with each result item.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_LINE      = 3'd1,
        EV_LONG      = 3'd2,
        EV_TIMEOUT   = 3'd3,
        EV_FRAME     = 3'd4,
        EV_FRAME_ERR = 3'd5
    } t_event;

    // Input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [2:0]  event_res;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        line_byte_valid;
        logic [6:0]  line_byte_index;
        logic [15:0] source_address;
        logic [7:0]  frame_length;
        logic        timeout_seen;
        logic [2:0]  mode_now;
    } t_out_item;

    // Hex digit decode result.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Decodes one ASCII hex digit, either case.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Characters of the ",TimeOut" prefix by position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2C;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6D;
            3'd4:    c = 8'h65;
            3'd5:    c = 8'h4F;
            3'd6:    c = 8'h75;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/at_response_and_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// at_response_and_frame_parser
// Parses the UART byte stream of a radio module into AT response lines and
// received frames, and passes frame payload bytes out.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall   i_in  (t_in_item)
//   out       output     o_out_valid / i_out_stall o_out (t_out_item)
//   config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each item passes through the input register, then through the parser logic
// into the result register.
// One item is accepted per cycle when the output side is not stalled; the
// rate is set by the single parser update between the two registers.
// A stall on the output holds the result register, and the input register
// then stalls the input side once it is also full.
// Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module at_response_and_frame_parser
    import atrfp_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in,
    // Output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // Line counter must hold LINE_SIZE + 1.
    localparam int LC_W = $clog2(LINE_SIZE + 2);
    localparam logic [LC_W-1:0] LC_PREFIX = LC_W'(PREFIX_LEN);
    localparam logic [LC_W-1:0] LC_SIZE   = LC_W'(LINE_SIZE);

    // Configuration register.
    logic r_timeout_en;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Parser state and next values.
    t_mode           r_mode,   n_mode;
    logic [7:0]      r_hdr,    n_hdr;
    t_step           r_step,   n_step;
    logic [8:0]      r_fc,     n_fc;
    logic [15:0]     r_addr,   n_addr;
    logic [7:0]      r_len,    n_len;
    logic [LC_W-1:0] r_lc,     n_lc;
    logic            r_pm,     n_pm;
    logic            r_to,     n_to;
    logic [15:0]     r_hacc,   n_hacc;
    logic            r_hok,    n_hok;

    // Result fields of the item in process.
    t_event     ev;
    logic       pv;
    logic [7:0] pb;
    logic       lv;
    logic [6:0] li;

    logic            advance;
    logic            process;
    logic [7:0]      c;
    t_hex            hx;
    logic [LC_W-1:0] lc_inc;
    logic [8:0]      fc_inc;

    // Handshake: the result register frees up when it is empty or taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration port: always ready, one register.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_TIMEOUT_EN[PADDR_W-1]) begin
            prdata = PDATA_W'(r_timeout_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_en <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_TIMEOUT_EN[PADDR_W-1]) begin
            r_timeout_en <= pwdata[0];
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Parser next state and result for the item in the input register.
    always_comb begin
        n_mode = r_mode;
        n_hdr  = r_hdr;
        n_step = r_step;
        n_fc   = r_fc;
        n_addr = r_addr;
        n_len  = r_len;
        n_lc   = r_lc;
        n_pm   = r_pm;
        n_to   = r_to;
        n_hacc = r_hacc;
        n_hok  = r_hok;
        ev     = EV_NONE;
        pv     = 1'b0;
        pb     = 8'd0;
        lv     = 1'b0;
        li     = 7'd0;
        c      = r_in.rx_byte;
        hx     = hex_decode(c);
        lc_inc = r_lc + LC_W'(1);
        fc_inc = r_fc + 9'd1;

        unique case (r_in.kind)
            KIND_BYTE: begin
                unique case (r_mode)
                    // Watch for the two-byte start markers.
                    MODE_HUNT: begin
                        if (r_hdr == CH_A && c == CH_T) begin
                            n_mode = MODE_LINE;
                            n_hdr  = 8'd0;
                        end else if (r_hdr == CH_L && c == CH_R) begin
                            n_mode = MODE_FRAME;
                            n_step = STEP_COMMA1;
                            n_fc   = 9'd0;
                            n_hdr  = 8'd0;
                        end else begin
                            n_hdr = c;
                        end
                    end
                    // Response line capture.
                    MODE_LINE: begin
                        if (r_lc < LC_PREFIX && c != prefix_char(r_lc[2:0])) begin
                            n_pm = 1'b0;
                        end
                        if (r_lc < LC_SIZE) begin
                            lv = 1'b1;
                            li = 7'(r_lc);
                        end
                        n_lc = lc_inc;
                        if (c == CH_LF && r_timeout_en && n_pm && lc_inc > LC_PREFIX) begin
                            n_to   = 1'b1;
                            n_lc   = '0;
                            n_pm   = 1'b1;
                            n_mode = MODE_HUNT;
                            ev     = EV_TIMEOUT;
                        end else begin
                            if (c == CH_LF) begin
                                n_mode = MODE_LINE_DONE;
                                ev     = EV_LINE;
                            end
                            // The overflow flag wins over a finished line.
                            if (lc_inc > LC_SIZE) begin
                                n_mode = MODE_LINE_LONG;
                                ev     = EV_LONG;
                            end
                        end
                    end
                    // Received frame header, payload and trailer.
                    MODE_FRAME: begin
                        unique case (r_step) inside
                            STEP_COMMA1, STEP_COMMA2, STEP_COMMA3: begin
                                if (c == CH_COMMA) begin
                                    n_fc   = 9'd0;
                                    n_hacc = 16'd0;
                                    n_hok  = 1'b1;
                                    n_step = t_step'(r_step + 3'd1);
                                end else begin
                                    n_step = STEP_COMMA1;
                                    n_mode = MODE_HUNT;
                                    ev     = EV_FRAME_ERR;
                                end
                            end
                            STEP_ADDR, STEP_LEN: begin
                                // Digits after the first non-hex one are dropped.
                                if (r_hok && hx.ok) begin
                                    n_hacc = {r_hacc[11:0], hx.value};
                                end else begin
                                    n_hok = 1'b0;
                                end
                                n_fc = fc_inc;
                                if (r_step == STEP_ADDR) begin
                                    if (fc_inc >= 9'd4) begin
                                        n_addr = n_hacc;
                                        n_step = STEP_COMMA2;
                                    end
                                end else if (fc_inc >= 9'd2) begin
                                    n_len  = n_hacc[7:0];
                                    n_step = STEP_COMMA3;
                                end
                            end
                            STEP_DATA: begin
                                n_fc = fc_inc;
                                if (fc_inc <= {1'b0, r_len}) begin
                                    pv = 1'b1;
                                    pb = c;
                                end
                                if (fc_inc >= {1'b0, r_len} + 9'd2) begin
                                    n_step = STEP_COMMA1;
                                    n_mode = MODE_HUNT;
                                    ev     = EV_FRAME;
                                end
                            end
                            default: begin
                                n_step = STEP_COMMA1;
                                n_mode = MODE_HUNT;
                                ev     = EV_FRAME_ERR;
                            end
                        endcase
                    end
                    default: begin
                        // Finished lines wait for the host release.
                    end
                endcase
            end
            KIND_RELEASE: begin
                n_mode = MODE_HUNT;
                n_lc   = '0;
                n_pm   = 1'b1;
            end
            KIND_CLR_TO: begin
                n_to = 1'b0;
            end
            default: begin
                // Unused kind changes nothing.
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUNT;
            r_hdr  <= 8'd0;
            r_step <= STEP_COMMA1;
            r_fc   <= 9'd0;
            r_addr <= 16'd0;
            r_len  <= 8'd0;
            r_lc   <= '0;
            r_pm   <= 1'b1;
            r_to   <= 1'b0;
            r_hacc <= 16'd0;
            r_hok  <= 1'b1;
        end else if (process) begin
            r_mode <= n_mode;
            r_hdr  <= n_hdr;
            r_step <= n_step;
            r_fc   <= n_fc;
            r_addr <= n_addr;
            r_len  <= n_len;
            r_lc   <= n_lc;
            r_pm   <= n_pm;
            r_to   <= n_to;
            r_hacc <= n_hacc;
            r_hok  <= n_hok;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out.event_res       <= ev;
            r_out.payload_valid   <= pv;
            r_out.payload_byte    <= pb;
            r_out.line_byte_valid <= lv;
            r_out.line_byte_index <= li;
            r_out.source_address  <= n_addr;
            r_out.frame_length    <= n_len;
            r_out.timeout_seen    <= n_to;
            r_out.mode_now        <= n_mode;
        end
    end

    // A result never carries both a payload byte and a line byte.
    a_one_byte_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.payload_valid && r_out.line_byte_valid))
        else $error("payload and line byte reported together");

    // A finished line leaves the parser in line done mode.
    a_line_done_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_LINE) |-> (r_out.mode_now == MODE_LINE_DONE))
        else $error("line done without line done mode");

    // A timeout line always raises the sticky flag.
    a_timeout_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_TIMEOUT) |-> r_out.timeout_seen)
        else $error("timeout event without timeout flag");

    // The line counter never runs past one beyond the buffer size.
    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lc <= LC_SIZE + LC_W'(1))
        else $error("line counter out of range");

    // The parser state only moves when an item is processed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(process) && $past(i_rst_n) |-> $stable(r_mode) && $stable(r_lc))
        else $error("parser state changed without an item");

endmodule
`default_nettype wire
